// ===== sv/wvr_pkg.sv =====
// ============================================================================
// Wind v-component rotator package
// Shared constants, the arctangent table and the stage payload type.
// ============================================================================
package wvr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int DATA_BITS     = 16;

    // Field widths.
    localparam int FIELD_W = 16;

    // Angle constants in Q2.13 radians.
    localparam logic signed [FIELD_W:0] PI_Q13      = 17'sd25736;
    localparam logic signed [FIELD_W:0] HALF_PI_Q13 = 17'sd12868;

    // Reciprocal of the CORDIC gain, Q1.30.
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    // Product of a Q8.8 field and the gain, and the shift into the datapath.
    localparam int PROD_W    = FIELD_W + 32;
    localparam int PRE_SHIFT = 38 - DATA_BITS;

    // Datapath: DATA_BITS fraction bits, eight integer bits with the sign, one bit
    // of growth for the diagonal magnitude and one spare.
    localparam int DP_W = DATA_BITS + 10;

    // Residual angle in units of 2^-24 rad.
    localparam int Z_W = 27;

    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

    localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        27'sd13176795, 27'sd7778716, 27'sd4110060, 27'sd2086331,
        27'sd1047214,  27'sd524117,  27'sd262123,  27'sd131069,
        27'sd65536,    27'sd32768,   27'sd16384,   27'sd8192,
        27'sd4096,     27'sd2048,    27'sd1024,    27'sd512,
        27'sd256,      27'sd128,     27'sd64,      27'sd32,
        27'sd16,       27'sd8,       27'sd4,       27'sd2
    };

    // Output rounding and the width left after dropping the extra fraction bits.
    localparam int RND_SHIFT = DATA_BITS - 8;
    localparam int RND_W     = DP_W + 1 - RND_SHIFT;

    typedef struct packed {
        logic                   neg;
        logic signed [DP_W-1:0] x;
        logic signed [DP_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

endpackage

// ===== sv/wvr_if.sv =====
// ============================================================================
// Wind v-component rotator channels
// Valid/ready channels for the vector requests and the rotated results.
// ============================================================================
interface wvr_vec_if;
    import wvr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] east_comp;
    logic signed [FIELD_W-1:0] north_comp;
    logic signed [FIELD_W-1:0] rot_angle;

    modport source (output valid, output east_comp, output north_comp,
                    output rot_angle, input ready);
    modport sink   (input valid, input east_comp, input north_comp,
                    input rot_angle, output ready);
endinterface

interface wvr_res_if;
    import wvr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] rotated_north;

    modport source (output valid, output rotated_north, input ready);
    modport sink   (input valid, input rotated_north, output ready);
endinterface

// ===== sv/wind_v_component_rotator.sv =====
// ============================================================================
// Wind v-component rotator
// Rotates a wind vector into a local grid frame and returns the v component.
// ============================================================================
//
//  Channel | Direction | Payload                              | Format
//  --------+-----------+--------------------------------------+--------------
//  vec     | in        | east_comp, north_comp, rot_angle     | Q8.8, Q2.13
//  res     | out       | rotated_north                        | Q8.8, saturated
//
// One request is taken per cycle while the chain advances. Its result passes
// through one register for the gain multiply and angle folding, one per
// CORDIC cell, and one for rounding into the output register.
// Reset clears only the valid bits along the chain; the payload registers
// are left as they are.
// The whole chain advances together whenever the output register is empty or
// its result is being taken; while the output is stalled, vec.ready is low.
//
module wind_v_component_rotator
    import wvr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    wvr_vec_if.sink      vec,
    wvr_res_if.source    res
);

    // The chain moves as one, gated only by the output register.
    logic    adv;
    logic    chain_valid [CORDIC_STAGES+1];
    cordic_t chain_data  [CORDIC_STAGES+1];
    logic    res_valid;

    assign adv       = !res_valid || res.ready;
    assign vec.ready = adv;
    assign res.valid = res_valid;

    // Scale the components by the inverse CORDIC gain and fold the angle so that
    // the rotation always stays within the range where CORDIC converges.
    wvr_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (vec.valid),
        .east_comp  (vec.east_comp),
        .north_comp (vec.north_comp),
        .rot_angle  (vec.rot_angle),
        .out_valid  (chain_valid[0]),
        .out_data   (chain_data[0])
    );

    // A row of identical cells; each performs one micro-rotation with its own
    // shift and arctangent entry and passes the vector on to its neighbour.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        wvr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .stage     (ATAN_IDX_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // Rounding to Q8.8 and saturation, registered as the result of the request.
    wvr_round u_round (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (adv),
        .in_valid      (chain_valid[CORDIC_STAGES]),
        .in_data       (chain_data[CORDIC_STAGES]),
        .out_valid     (res_valid),
        .rotated_north (res.rotated_north)
    );

endmodule

// ===== sv/wvr_prep.sv =====
// ============================================================================
// Wind v-component rotator input stage
// Scales u and v by the inverse gain and folds the angle into range.
// ============================================================================
module wvr_prep
    import wvr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [FIELD_W-1:0] east_comp,
    input  logic signed [FIELD_W-1:0] north_comp,
    input  logic signed [FIELD_W-1:0] rot_angle,
    output logic                      out_valid,
    output cordic_t                   out_data
);

    logic                      valid_reg;
    cordic_t                   data_reg;
    cordic_t                   data_next;
    logic signed [FIELD_W:0]   ang;
    logic signed [FIELD_W:0]   th_fold;
    logic signed [FIELD_W:0]   th;
    logic signed [Z_W-1:0]     th_z;
    logic signed [PROD_W-1:0]  prod_u;
    logic signed [PROD_W-1:0]  prod_v;

    always_comb
    begin
        ang     = (FIELD_W + 1)'(rot_angle);
        th_fold = (ang < HALF_PI_Q13) ? ang : (PI_Q13 - ang);
        // Past minus a quarter turn the rotation would not converge, so turn by
        // half a revolution more and flip the sign of the result at the end.
        data_next.neg = (th_fold < -HALF_PI_Q13);
        th      = data_next.neg ? (th_fold + PI_Q13) : th_fold;
        th_z    = Z_W'(th);
        data_next.z = -(th_z <<< 11);

        prod_u = PROD_W'(east_comp) * PROD_W'(GAIN_Q30);
        prod_v = PROD_W'(north_comp) * PROD_W'(GAIN_Q30);
        data_next.x = DP_W'(prod_u >>> PRE_SHIFT);
        data_next.y = DP_W'(prod_v >>> PRE_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/wvr_cell.sv =====
// ============================================================================
// Wind v-component rotator CORDIC cell
// One micro-rotation of the chain, with its own pipeline register.
// ============================================================================
module wvr_cell
    import wvr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [ATAN_IDX_W-1:0] stage,
    input  logic                  in_valid,
    input  cordic_t               in_data,
    output logic                  out_valid,
    output cordic_t               out_data
);

    logic                   valid_reg;
    cordic_t                data_reg;
    cordic_t                data_next;
    logic signed [DP_W-1:0] xs;
    logic signed [DP_W-1:0] ys;
    logic signed [Z_W-1:0]  step;

    always_comb
    begin
        xs   = in_data.x >>> stage;
        ys   = in_data.y >>> stage;
        step = ATAN_TAB[stage];
        data_next.neg = in_data.neg;
        // Turn towards a zero residual angle.
        if (in_data.z >= 0)
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - step;
        end
        else
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/wvr_round.sv =====
// ============================================================================
// Wind v-component rotator output stage
// Rounds the rotated v component to Q8.8, saturates it and holds it.
// ============================================================================
module wvr_round
    import wvr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  cordic_t                   in_data,
    output logic                      out_valid,
    output logic signed [FIELD_W-1:0] rotated_north
);

    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(32767);
    localparam logic signed [RND_W-1:0] SAT_LO = -RND_W'(32768);
    localparam logic signed [DP_W:0]    RND_HALF = (DP_W + 1)'(1) <<< (DATA_BITS - 9);

    logic                      valid_reg;
    logic signed [FIELD_W-1:0] value_reg;
    logic signed [FIELD_W-1:0] value_next;
    logic signed [DP_W:0]      y_ext;
    logic signed [DP_W:0]      y_sum;
    logic signed [RND_W-1:0]   r;

    always_comb
    begin
        y_ext = (DP_W + 1)'(in_data.y);
        y_sum = (in_data.neg ? -y_ext : y_ext) + RND_HALF;
        r     = RND_W'(y_sum >>> RND_SHIFT);
        if (r > SAT_HI)
        begin
            value_next = FIELD_W'(SAT_HI);
        end
        else if (r < SAT_LO)
        begin
            value_next = FIELD_W'(SAT_LO);
        end
        else
        begin
            value_next = FIELD_W'(r);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
        end
    end

    assign out_valid     = valid_reg;
    assign rotated_north = value_reg;

endmodule
